FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/dda_pkg.sv
// Types and codes shared by the DDA line rasterizer and its checker.
package dda_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV_X,
    ST_DIV_Y
  } state_t;

endpackage

FILE: rtl/dda_line_rasterizer.sv
// A start item is taken, then the shared restoring divider computes the x and y increments
// in turn before the next item is taken. Equal endpoints skip the divider. Step items are
// taken one per cycle while the output is not stalled; each point appears in the output
// register the cycle after its step item, and a stalled output holds input.
// Reset (rst_n, synchronous, active low) clears the sequencer, the point count and
// the output valid.
module dda_line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  // operation
  input  logic                                     in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // point_x, point_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        out_tdata,
  output logic                                     out_tlast
);

  localparam int CW   = COORD_BITS;
  localparam int FW   = FRAC_BITS;
  localparam int AW   = CW + FW;
  localparam int IW   = FW + 2;
  localparam int PW   = CW + 1;
  localparam int RW   = CW + 1;
  localparam int QW   = FW + 1;
  localparam int CNTW = $clog2(FW + 1);
  localparam logic [AW-1:0] HALF = AW'(1) << (FW - 1);

  dda_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   x_acc_r, x_acc_nxt, y_acc_r, y_acc_nxt;
  logic [IW-1:0]   x_inc_r, x_inc_nxt, y_inc_r, y_inc_nxt;
  logic [PW-1:0]   pts_r, pts_nxt;
  logic [CW-1:0]   steps_r, steps_nxt, mag_y_r, mag_y_nxt;
  logic            neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]   out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic            out_last_r, out_last_nxt, out_valid_r, out_valid_nxt;

  logic [CW-1:0]   sx, sy, ex, ey, ax, ay, steps;
  logic [RW-1:0]   shifted;
  logic [RW:0]     trial;
  logic            ge, last_iter, accept;
  logic [CW-1:0]   rem_new;
  logic [QW-1:0]   quo_new;
  logic [IW-1:0]   qext, inc_pos, inc_neg;
  logic [AW-1:0]   x_round, y_round;

  assign sx = in_tdata[CW-1:0];
  assign sy = in_tdata[2*CW-1:CW];
  assign ex = in_tdata[3*CW-1:2*CW];
  assign ey = in_tdata[4*CW-1:3*CW];
  assign ax = (ex >= sx) ? ex - sx : sx - ex;
  assign ay = (ey >= sy) ? ey - sy : sy - ey;
  assign steps = (ax > ay) ? ax : ay;

  assign in_tready = (state_r == dda_pkg::ST_RUN) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // One restoring division step; the first step yields the integer bit unshifted.
  assign shifted   = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign trial     = {1'b0, shifted} - {2'b00, steps_r};
  assign ge        = !trial[RW];
  assign rem_new   = ge ? trial[CW-1:0] : shifted[CW-1:0];
  assign quo_new   = {quo_r[QW-2:0], ge};
  assign last_iter = (cnt_r == CNTW'(FW));
  assign qext      = {1'b0, quo_new};
  assign inc_pos   = qext;
  assign inc_neg   = IW'(0) - qext;

  assign x_round = x_acc_r + HALF;
  assign y_round = y_acc_r + HALF;

  always_comb begin
    state_nxt     = state_r;
    x_acc_nxt     = x_acc_r;
    y_acc_nxt     = y_acc_r;
    x_inc_nxt     = x_inc_r;
    y_inc_nxt     = y_inc_r;
    pts_nxt       = pts_r;
    steps_nxt     = steps_r;
    mag_y_nxt     = mag_y_r;
    neg_x_nxt     = neg_x_r;
    neg_y_nxt     = neg_y_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      dda_pkg::ST_RUN: begin
        if (accept && (in_tuser == dda_pkg::OP_START)) begin
          x_acc_nxt = {sx, FW'(0)};
          y_acc_nxt = {sy, FW'(0)};
          pts_nxt   = {1'b0, steps} + PW'(1);
          steps_nxt = steps;
          mag_y_nxt = ay;
          neg_x_nxt = ex < sx;
          neg_y_nxt = ey < sy;
          rem_nxt   = ax;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          if (steps == '0) begin
            x_inc_nxt = '0;
            y_inc_nxt = '0;
          end else begin
            state_nxt = dda_pkg::ST_DIV_X;
          end
        end else if (accept && (pts_r != '0)) begin
          out_x_nxt     = x_round[AW-1:FW];
          out_y_nxt     = y_round[AW-1:FW];
          out_last_nxt  = (pts_r == PW'(1));
          out_valid_nxt = 1'b1;
          x_acc_nxt     = x_acc_r + {{(AW-IW){x_inc_r[IW-1]}}, x_inc_r};
          y_acc_nxt     = y_acc_r + {{(AW-IW){y_inc_r[IW-1]}}, y_inc_r};
          pts_nxt       = pts_r - PW'(1);
        end
      end
      dda_pkg::ST_DIV_X: begin
        rem_nxt = rem_new;
        quo_nxt = quo_new;
        cnt_nxt = CNTW'(cnt_r + 1'b1);
        if (last_iter) begin
          x_inc_nxt = neg_x_r ? inc_neg : inc_pos;
          rem_nxt   = mag_y_r;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = dda_pkg::ST_DIV_Y;
        end
      end
      dda_pkg::ST_DIV_Y: begin
        rem_nxt = rem_new;
        quo_nxt = quo_new;
        cnt_nxt = CNTW'(cnt_r + 1'b1);
        if (last_iter) begin
          y_inc_nxt = neg_y_r ? inc_neg : inc_pos;
          state_nxt = dda_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = dda_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dda_pkg::ST_RUN;
      pts_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pts_r       <= pts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_acc_r    <= x_acc_nxt;
    y_acc_r    <= y_acc_nxt;
    x_inc_r    <= x_inc_nxt;
    y_inc_r    <= y_inc_nxt;
    steps_r    <= steps_nxt;
    mag_y_r    <= mag_y_nxt;
    neg_x_r    <= neg_x_nxt;
    neg_y_r    <= neg_y_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    out_tdata             = '0;
    out_tdata[2*CW-1:0]   = {out_y_r, out_x_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/dda_checker.sv
// Port-level checker for the DDA line rasterizer, bound to the top level.
`include "assert_macros.svh"

module dda_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tuser,
  input logic out_tvalid,
  input logic out_tready,
  input logic out_tlast
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_IMPL(a_no_take_when_blocked, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  `ASSERT_NEXT(a_start_no_item, clk, rst_n,
               !out_tvalid && in_tvalid && in_tready && (in_tuser == dda_pkg::OP_START),
               !out_tvalid)
  `ASSERT_NEXT(a_last_ends_line, clk, rst_n, out_tvalid && out_tready && out_tlast, !out_tvalid)

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tlast  (out_tlast)
);
